// ===== src/mhap_pkg.sv =====
// mhap_pkg: shared constants and helpers for the 802.15.4 MAC header address parser.
// Depends on nothing; used by mac_header_address_parser_core.
package mhap_pkg;

  localparam int EXT_ADDR_BYTES = 8;
  localparam int CNT_W          = 5;

  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_RESERVED = 2'd1;
  localparam logic [1:0] MODE_SHORT    = 2'd2;
  localparam logic [1:0] MODE_EXT      = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RESERVED = 2'd1;
  localparam logic [1:0] ST_KEY_ID   = 2'd2;
  localparam logic [1:0] ST_SHORT    = 2'd3;

  localparam logic [CNT_W-1:0] PAN_BYTES     = 5'd2;
  localparam logic [CNT_W-1:0] SHORT_BYTES   = 5'd2;
  localparam logic [CNT_W-1:0] SEC_BYTES     = 5'd5;
  localparam logic [6:0]       HDR_BASE      = 7'd3;
  localparam logic [6:0]       MIC_BYTES     = 7'd4;

  function automatic logic [CNT_W-1:0] addr_len(input logic [1:0] mode);
    logic [CNT_W-1:0] n;
    unique case (mode)
      MODE_SHORT: n = SHORT_BYTES;
      MODE_EXT:   n = CNT_W'(EXT_ADDR_BYTES);
      default:    n = '0;
    endcase
    return n;
  endfunction

endpackage

// ===== src/mac_header_address_parser_core.sv =====
// mac_header_address_parser_core: 802.15.4 MAC header address parser.
// Latency: result valid in the cycle after the input transfer that completes a header.
// Throughput: one header byte per cycle; input stalls only while a result waits.
// Each byte is decoded by short logic into the parse state and the result register.
// Reset (rst, synchronous) clears the parse state and drops any pending result.
// Depends on mhap_pkg.
module mac_header_address_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        frame_start,
  input  logic [1:0]  dest_mode,
  input  logic [1:0]  src_mode,
  input  logic        pan_compress,
  input  logic        security_on,
  input  logic [6:0]  frame_length,
  input  logic [7:0]  header_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [15:0] dst_pan,
  output logic [63:0] dest_address,
  output logic [15:0] src_pan,
  output logic [63:0] src_address,
  output logic [6:0]  payload_offset,
  output logic [6:0]  payload_length,
  output logic [1:0]  status
);

  localparam int CW = mhap_pkg::CNT_W;

  logic          busy;
  logic [CW-1:0] byte_count;
  logic [1:0]    lat_dest_mode, lat_src_mode;
  logic          lat_compress, lat_secure;
  logic [6:0]    lat_length;
  logic [15:0]   dpan, span;
  logic [63:0]   daddr, saddr;

  logic          accept;
  logic [1:0]    e_dm, e_sm;
  logic          e_comp, e_sec;
  logic [6:0]    e_len;
  logic [CW-1:0] i, d, p, s, sec, dps, hdr, i_inc;
  logic          reserved, active, keyid, last, final_emit, emit;
  logic          busy_next;
  logic [CW-1:0] byte_count_next;
  logic [15:0]   dpan_next, span_next;
  logic [63:0]   daddr_next, saddr_next;
  logic [CW-1:0] rel_d, rel_p, rel_s;
  logic [6:0]    off, diff, r_off, r_len;
  logic [1:0]    r_st;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  always_comb begin
    e_dm   = frame_start ? dest_mode    : lat_dest_mode;
    e_sm   = frame_start ? src_mode     : lat_src_mode;
    e_comp = frame_start ? pan_compress : lat_compress;
    e_sec  = frame_start ? security_on  : lat_secure;
    e_len  = frame_start ? frame_length : lat_length;
    i      = frame_start ? '0 : byte_count;

    reserved = frame_start && (dest_mode == mhap_pkg::MODE_RESERVED ||
                               src_mode == mhap_pkg::MODE_RESERVED);

    d   = (e_dm == mhap_pkg::MODE_SHORT || e_dm == mhap_pkg::MODE_EXT) ?
          mhap_pkg::PAN_BYTES + mhap_pkg::addr_len(e_dm) : '0;
    p   = ((e_sm == mhap_pkg::MODE_SHORT || e_sm == mhap_pkg::MODE_EXT) && !e_comp) ?
          mhap_pkg::PAN_BYTES : '0;
    s   = mhap_pkg::addr_len(e_sm);
    sec = e_sec ? mhap_pkg::SEC_BYTES : '0;
    dps = d + p + s;
    hdr = dps + sec;
    i_inc = i + 1'b1;

    active = frame_start ? (!reserved && hdr != '0) : busy;

    dpan_next  = frame_start ? '0 : dpan;
    daddr_next = frame_start ? '0 : daddr;
    span_next  = frame_start ? '0 : span;
    saddr_next = frame_start ? '0 : saddr;
    rel_d = i - mhap_pkg::PAN_BYTES;
    rel_p = i - d;
    rel_s = i - d - p;
    keyid = 1'b0;
    if (active) begin
      if (i < d) begin
        if (i < mhap_pkg::PAN_BYTES) dpan_next[8*i[0] +: 8] = header_byte;
        else daddr_next[8*rel_d[2:0] +: 8] = header_byte;
      end else if (i < d + p) begin
        span_next[8*rel_p[0] +: 8] = header_byte;
      end else if (i < dps) begin
        saddr_next[8*rel_s[2:0] +: 8] = header_byte;
      end else if (i == dps) begin
        keyid = header_byte[4:3] != 2'b00;
      end
    end

    last       = active && !keyid && (i_inc >= hdr);
    final_emit = (frame_start && !reserved && hdr == '0) || last;
    emit       = reserved || keyid || final_emit;

    busy_next       = active && !keyid && !last;
    byte_count_next = busy_next ? i_inc : '0;

    off  = mhap_pkg::HDR_BASE + 7'(hdr);
    diff = e_len - off;
    r_st = mhap_pkg::ST_OK;
    r_len = '0;
    if (reserved) begin
      r_off = mhap_pkg::HDR_BASE;
      r_st  = mhap_pkg::ST_RESERVED;
    end else if (keyid) begin
      r_off = '0;
      r_st  = mhap_pkg::ST_KEY_ID;
    end else begin
      r_off = off;
      if (e_len < off) begin
        r_st = mhap_pkg::ST_SHORT;
      end else if (e_sec && diff != '0) begin
        if (diff < mhap_pkg::MIC_BYTES) r_st = mhap_pkg::ST_SHORT;
        else r_len = diff - mhap_pkg::MIC_BYTES;
      end else begin
        r_len = diff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      byte_count    <= '0;
      lat_dest_mode <= '0;
      lat_src_mode  <= '0;
      lat_compress  <= 1'b0;
      lat_secure    <= 1'b0;
      lat_length    <= '0;
      dpan          <= '0;
      daddr         <= '0;
      span          <= '0;
      saddr         <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (accept) begin
        busy       <= busy_next;
        byte_count <= byte_count_next;
        dpan       <= dpan_next;
        daddr      <= daddr_next;
        span       <= span_next;
        saddr      <= saddr_next;
        if (frame_start) begin
          lat_dest_mode <= dest_mode;
          lat_src_mode  <= src_mode;
          lat_compress  <= pan_compress;
          lat_secure    <= security_on;
          lat_length    <= frame_length;
        end
      end
      if (accept && emit) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      dst_pan        <= dpan_next;
      dest_address   <= daddr_next;
      src_pan        <= e_comp ? dpan_next : span_next;
      src_address    <= saddr_next;
      payload_offset <= r_off;
      payload_length <= r_len;
      status         <= r_st;
    end
  end

endmodule

// ===== sim/mac_header_address_parser_core_tb.sv =====
// Self-checking bench for mac_header_address_parser_core: frames of header bytes, random stalls.
// A scoreboard class predicts each result per transfer; depends on mhap_pkg and the core.
module mac_header_address_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       fs;
    logic [1:0] dm;
    logic [1:0] sm;
    logic       pc;
    logic       so;
    logic [6:0] len;
    logic [7:0] b;
  } hdr_byte_t;

  typedef struct packed {
    logic [15:0] dpan;
    logic [63:0] daddr;
    logic [15:0] span;
    logic [63:0] saddr;
    logic [6:0]  off;
    logic [6:0]  plen;
    logic [1:0]  st;
  } addr_result_t;

  class addr_parse_scoreboard;
    addr_result_t expected_headers[$];
    int mismatches;
    int results_checked;
    int frames_expected;
    bit parsing;
    int unsigned consumed;
    bit [1:0] dm_q, sm_q;
    bit pc_q, so_q;
    bit [6:0] len_q;
    bit [15:0] dpan_q, span_q;
    bit [63:0] daddr_q, saddr_q;

    static function int unsigned addr_bytes(bit [1:0] m);
      if (m == mhap_pkg::MODE_SHORT) return 2;
      if (m == mhap_pkg::MODE_EXT) return mhap_pkg::EXT_ADDR_BYTES;
      return 0;
    endfunction

    static function void field_sizes(bit [1:0] dm, bit [1:0] sm, bit pc, bit so,
                                     output int unsigned d, output int unsigned p,
                                     output int unsigned s, output int unsigned sec);
      d = (addr_bytes(dm) == 0) ? 0 : 2 + addr_bytes(dm);
      p = (addr_bytes(sm) != 0 && !pc) ? 2 : 0;
      s = addr_bytes(sm);
      sec = so ? 5 : 0;
    endfunction

    function void push_result(bit [6:0] off, bit [6:0] plen, bit [1:0] st);
      addr_result_t r;
      r.dpan  = dpan_q;
      r.daddr = daddr_q;
      r.span  = pc_q ? dpan_q : span_q;
      r.saddr = saddr_q;
      r.off   = off;
      r.plen  = plen;
      r.st    = st;
      expected_headers.push_back(r);
      frames_expected++;
    endfunction

    function void push_final(int unsigned hdr);
      int unsigned off;
      int unsigned plen;
      bit [1:0] st;
      off = mhap_pkg::HDR_BASE + hdr;
      plen = 0;
      st = mhap_pkg::ST_OK;
      if (len_q < off) begin
        st = mhap_pkg::ST_SHORT;
      end else begin
        plen = len_q - off;
        if (so_q && plen > 0) begin
          if (plen < mhap_pkg::MIC_BYTES) begin
            plen = 0;
            st = mhap_pkg::ST_SHORT;
          end else begin
            plen = plen - mhap_pkg::MIC_BYTES;
          end
        end
      end
      push_result(off[6:0], plen[6:0], st);
    endfunction

    function void note_input(hdr_byte_t x);
      int unsigned d, p, s, sec, i;
      if (x.fs) begin
        dm_q = x.dm;
        sm_q = x.sm;
        pc_q = x.pc;
        so_q = x.so;
        len_q = x.len;
        consumed = 0;
        dpan_q = '0;
        daddr_q = '0;
        span_q = '0;
        saddr_q = '0;
        parsing = 0;
        if (x.dm == mhap_pkg::MODE_RESERVED || x.sm == mhap_pkg::MODE_RESERVED) begin
          push_result(mhap_pkg::HDR_BASE, 7'd0, mhap_pkg::ST_RESERVED);
          return;
        end
        field_sizes(dm_q, sm_q, pc_q, so_q, d, p, s, sec);
        if (d + p + s + sec == 0) begin
          push_final(0);
          return;
        end
        parsing = 1;
      end else if (!parsing) begin
        return;
      end
      field_sizes(dm_q, sm_q, pc_q, so_q, d, p, s, sec);
      i = consumed;
      if (i < d) begin
        if (i < 2) dpan_q[8*i +: 8] = x.b;
        else daddr_q[8*((i-2)%8) +: 8] = x.b;
      end else if (i < d + p) begin
        span_q[8*((i-d)%2) +: 8] = x.b;
      end else if (i < d + p + s) begin
        saddr_q[8*((i-d-p)%8) +: 8] = x.b;
      end else if (i == d + p + s && x.b[4:3] != 2'b00) begin
        parsing = 0;
        consumed = 0;
        push_result(7'd0, 7'd0, mhap_pkg::ST_KEY_ID);
        return;
      end
      consumed = (i + 1) % 32;
      if (i + 1 >= d + p + s + sec) begin
        parsing = 0;
        consumed = 0;
        push_final(d + p + s + sec);
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(addr_result_t got);
      addr_result_t want;
      if (expected_headers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        mismatches++;
        return;
      end
      want = expected_headers.pop_front();
      results_checked++;
      compare_field("dst_pan", want.dpan, got.dpan);
      compare_field("dest_address", want.daddr, got.daddr);
      compare_field("src_pan", want.span, got.span);
      compare_field("src_address", want.saddr, got.saddr);
      compare_field("payload_offset", want.off, got.off);
      compare_field("payload_length", want.plen, got.plen);
      compare_field("status", want.st, got.st);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  logic        frame_start;
  logic [1:0]  dest_mode;
  logic [1:0]  src_mode;
  logic        pan_compress;
  logic        security_on;
  logic [6:0]  frame_length;
  logic [7:0]  header_byte;
  logic        result_valid;
  logic        result_ready;
  logic [15:0] dst_pan;
  logic [63:0] dest_address;
  logic [15:0] src_pan;
  logic [63:0] src_address;
  logic [6:0]  payload_offset;
  logic [6:0]  payload_length;
  logic [1:0]  status;

  addr_parse_scoreboard sb = new();
  bit calm;
  bit hold_req;
  int bytes_sent;

  mac_header_address_parser_core uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .frame_start(frame_start), .dest_mode(dest_mode), .src_mode(src_mode),
    .pan_compress(pan_compress), .security_on(security_on),
    .frame_length(frame_length), .header_byte(header_byte),
    .result_valid(result_valid), .result_ready(result_ready),
    .dst_pan(dst_pan), .dest_address(dest_address),
    .src_pan(src_pan), .src_address(src_address),
    .payload_offset(payload_offset), .payload_length(payload_length),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(3_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [1:0] pick_mode();
    if ($urandom_range(0, 19) == 0) return mhap_pkg::MODE_RESERVED;
    case ($urandom_range(0, 2))
      0: return mhap_pkg::MODE_NONE;
      1: return mhap_pkg::MODE_SHORT;
      default: return mhap_pkg::MODE_EXT;
    endcase
  endfunction

  task automatic send_item(input logic fs, input logic [1:0] dm, input logic [1:0] sm,
                           input logic pc, input logic so, input logic [6:0] len,
                           input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < 16) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    item_valid   <= 1'b1;
    frame_start  <= fs;
    dest_mode    <= dm;
    src_mode     <= sm;
    pan_compress <= pc;
    security_on  <= so;
    frame_length <= len;
    header_byte  <= b;
    do @(posedge clk); while (!item_ready);
    sb.note_input(hdr_byte_t'{fs, dm, sm, pc, so, len, b});
  endtask

  // stop_at > 0 cuts the frame short; bad_key sets key id bits in the security control byte
  task automatic send_frame(input logic [1:0] dm, input logic [1:0] sm, input logic pc,
                            input logic so, input logic [6:0] len, input int stop_at,
                            input bit bad_key, input int pat);
    int unsigned d, p, s, sec, n;
    logic [7:0] b;
    addr_parse_scoreboard::field_sizes(dm, sm, pc, so, d, p, s, sec);
    n = d + p + s + sec;
    if (n == 0 || dm == mhap_pkg::MODE_RESERVED || sm == mhap_pkg::MODE_RESERVED) n = 1;
    if (stop_at > 0 && stop_at < n) n = stop_at;
    for (int k = 0; k < n; k++) begin
      b = (pat < 0) ? 8'($urandom) : 8'(pat);
      if (sec != 0 && k == d + p + s) begin
        b[4:3] = bad_key ? 2'($urandom_range(1, 3)) : 2'b00;
      end
      if (k == 0) send_item(1'b1, dm, sm, pc, so, len, b);
      else send_item(1'b0, 2'($urandom), 2'($urandom), 1'($urandom), 1'($urandom),
                     7'($urandom), b);
      bytes_sent++;
      if (bad_key && sec != 0 && k == d + p + s) break;
    end
  endtask

  initial begin
    int hold;
    hold = 0;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) begin
        sb.check_result(addr_result_t'{dst_pan, dest_address, src_pan, src_address,
                                       payload_offset, payload_length, status});
      end
      if (hold_req) begin
        hold = 80;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= calm || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  initial begin
    logic [1:0] dm, sm;
    logic pc, so;
    logic [6:0] len;
    int unsigned d, p, s, sec;
    int off, t, r, hold_at;
    bit idle;

    rst          <= 1'b1;
    item_valid   <= 1'b0;
    frame_start  <= 1'b0;
    dest_mode    <= mhap_pkg::MODE_NONE;
    src_mode     <= mhap_pkg::MODE_NONE;
    pan_compress <= 1'b0;
    security_on  <= 1'b0;
    frame_length <= '0;
    header_byte  <= '0;
    calm = 1'b0;
    hold_req = 1'b0;
    bytes_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // stray byte while idle, then the corner frames
    send_item(1'b0, mhap_pkg::MODE_EXT, mhap_pkg::MODE_EXT, 1'b1, 1'b1, 7'd127, 8'hFF);
    send_frame(mhap_pkg::MODE_NONE, mhap_pkg::MODE_NONE, 1'b0, 1'b0, 7'd0, 0, 0, 8'h00);
    send_frame(mhap_pkg::MODE_NONE, mhap_pkg::MODE_NONE, 1'b1, 1'b0, 7'd127, 0, 0, 8'hFF);
    send_frame(mhap_pkg::MODE_RESERVED, mhap_pkg::MODE_SHORT, 1'b0, 1'b1, 7'd40, 0, 0,
               8'hA5);
    send_frame(mhap_pkg::MODE_EXT, mhap_pkg::MODE_RESERVED, 1'b1, 1'b0, 7'd40, 0, 0,
               8'h5A);
    send_frame(mhap_pkg::MODE_SHORT, mhap_pkg::MODE_NONE, 1'b0, 1'b0, 7'd7, 0, 0, 8'hFF);
    send_frame(mhap_pkg::MODE_NONE, mhap_pkg::MODE_SHORT, 1'b0, 1'b0, 7'd6, 0, 0, 8'h00);
    send_frame(mhap_pkg::MODE_NONE, mhap_pkg::MODE_NONE, 1'b0, 1'b1, 7'd20, 0, 1, -1);
    send_frame(mhap_pkg::MODE_NONE, mhap_pkg::MODE_NONE, 1'b0, 1'b1, 7'd9, 0, 0, -1);
    send_frame(mhap_pkg::MODE_EXT, mhap_pkg::MODE_EXT, 1'b0, 1'b0, 7'd60, 3, 0, -1);
    send_frame(mhap_pkg::MODE_SHORT, mhap_pkg::MODE_SHORT, 1'b1, 1'b0, 7'd11, 0, 0, -1);

    idle = 1'b1;
    bytes_sent = 0;
    hold_at = 30;
    while (bytes_sent < 400) begin
      calm = (bytes_sent >= 150 && bytes_sent < 250);
      if (bytes_sent >= hold_at) begin
        hold_req = 1'b1;
        hold_at += 250;
      end
      dm = pick_mode();
      sm = pick_mode();
      pc = 1'($urandom);
      so = 1'($urandom);
      addr_parse_scoreboard::field_sizes(dm, sm, pc, so, d, p, s, sec);
      off = 3 + d + p + s + sec;
      if ($urandom_range(0, 1)) begin
        t = off - 4 + $urandom_range(0, 12);
        if (t < 0) t = 0;
        if (t > 127) t = 127;
        len = 7'(t);
      end else begin
        len = 7'($urandom);
      end
      r = $urandom_range(0, 99);
      if (r < 5 && idle) begin
        send_item(1'b0, 2'($urandom), 2'($urandom), 1'($urandom), 1'($urandom),
                  7'($urandom), 8'($urandom));
      end else if (r < 12) begin
        send_frame(dm, sm, pc, so, len, $urandom_range(1, 24), 0, -1);
        idle = 1'b0;
      end else if (r < 20) begin
        send_frame(dm, sm, pc, so, len, 0, so, -1);
        idle = 1'b1;
      end else begin
        send_frame(dm, sm, pc, so, len, 0, 0, -1);
        idle = 1'b1;
      end
    end
    calm = 1'b0;

    item_valid <= 1'b0;
    while (sb.expected_headers.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    $display("Checked %0d parse results over %0d random header bytes, %0d mismatches.",
             sb.results_checked, bytes_sent, sb.mismatches);
    $display("Frames covered all address modes, compression, security, key id aborts, %s",
             "short lengths, restarts and stray bytes, under idling and output hold-off.");
    if (sb.mismatches == 0 && sb.expected_headers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
